// ===== hdl/dual_half_graphic_lcd_controller_macros.svh =====
// Assertion macros shared by the LCD controller modules.
`ifndef DUAL_HALF_GRAPHIC_LCD_CONTROLLER_MACROS_SVH
`define DUAL_HALF_GRAPHIC_LCD_CONTROLLER_MACROS_SVH

// Checked on every rising edge outside reset.
`define DHGLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DHGLC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/dhglc_pkg.sv =====
// Types, constants and sizes of the dual-half graphic LCD controller.
package dhglc_pkg;

  // Panel geometry
  localparam int unsigned PAGES     = 8;
  localparam int unsigned COLUMNS   = 64;
  localparam int unsigned HALVES    = 2;
  localparam int unsigned RAM_DEPTH = PAGES * COLUMNS;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
  localparam int unsigned PAGE_AW   = $clog2(PAGES);
  localparam int unsigned COL_AW    = $clog2(COLUMNS);

  // Register widths fixed by the controller's instruction set
  localparam int unsigned PAGE_W = 3;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned LINE_W = 6;

  // Instruction codes and masks
  localparam logic [7:0] INSTR_OFF       = 8'h3E;
  localparam logic [7:0] INSTR_ON        = 8'h3F;
  localparam logic [7:0] INSTR_COL_MASK  = 8'hC0;
  localparam logic [7:0] INSTR_COL       = 8'h40;
  localparam logic [7:0] INSTR_PAGE_MASK = 8'hF8;
  localparam logic [7:0] INSTR_PAGE      = 8'hB8;
  localparam logic [7:0] INSTR_LINE_MASK = 8'hC0;
  localparam logic [7:0] INSTR_LINE      = 8'hC0;

  // Status byte: only the display-off flag is ever set
  localparam logic [7:0] STATUS_OFF = 8'h20;

  typedef enum logic [1:0] {
    KIND_INSTR   = 2'd0,
    KIND_DATA_WR = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_DATA_RD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CS_BOTH  = 2'd0,
    CS_LEFT  = 2'd1,
    CS_RIGHT = 2'd2,
    CS_NONE  = 2'd3
  } cs_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LATCH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic              clr_en;
    logic [RAM_AW-1:0] clr_addr;
    logic              acc_en;
    logic              latch_ld;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dread_sel;
  } dp_status_t;

endpackage

// ===== hdl/dhglc_if.sv =====
// Request channels of the LCD controller: bus access in, result out.
interface dhglc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] chip_select;
  logic [7:0] bus_data;

  modport source (output valid, output kind, output chip_select, output bus_data,
                  input ready);
  modport sink   (input valid, input kind, input chip_select, input bus_data,
                  output ready);
endinterface

interface dhglc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       bus_driven;

  modport source (output valid, output read_data, output bus_driven, input ready);
  modport sink   (input valid, input read_data, input bus_driven, output ready);
endinterface

// ===== hdl/dhglc_ctrl.sv =====
// Controller: RAM clearing sweep, request acceptance and result register valid.
`include "dual_half_graphic_lcd_controller_macros.svh"

module dhglc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  dhglc_pkg::dp_status_t  status_i,
  output dhglc_pkg::ctrl_cmd_t   cmd_o
);
  import dhglc_pkg::*;

  state_e            state_q, state_d;
  logic [RAM_AW-1:0] clr_addr_q, clr_addr_d;
  logic              out_valid_q, out_valid_d;
  logic              acc;

  // State, sweep counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    clr_addr_d     = clr_addr_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_addr_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_addr_d   = clr_addr_q + 1'b1;
        if (clr_addr_q == RAM_AW'(RAM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // a new request may enter while the held result is being taken
        in_ready_o = !out_valid_q || out_ready_i;
      end
      ST_LATCH: begin
        cmd_o.latch_ld = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    acc          = in_valid_i && in_ready_o;
    cmd_o.acc_en = acc;
    if (acc && status_i.dread_sel) begin
      state_d = ST_LATCH;
    end

    if (acc) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  assign out_valid_o = out_valid_q;

  `DHGLC_ASSERT(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o, "request accepted during RAM clear")
  `DHGLC_ASSERT(a_dread_to_latch, (acc && status_i.dread_sel) |=> (state_q == ST_LATCH), "data read not followed by latch load")
  `DHGLC_ASSERT(a_clear_done, (state_q == ST_CLEAR && clr_addr_q == RAM_AW'(RAM_DEPTH - 1)) |=> (state_q == ST_IDLE), "clear sweep did not finish")
  `DHGLC_ASSERT_ALWAYS(a_clear_excl, !(cmd_o.clr_en && cmd_o.acc_en), "clear write collides with request")

endmodule

// ===== hdl/dhglc_dpath.sv =====
// Datapath: per-half registers, display RAMs, output latches and result register.
`include "dual_half_graphic_lcd_controller_macros.svh"

module dhglc_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhglc_pkg::ctrl_cmd_t  cmd_i,
  input  dhglc_pkg::kind_e      kind_i,
  input  dhglc_pkg::cs_e        cs_i,
  input  logic [7:0]            bus_data_i,
  output dhglc_pkg::dp_status_t status_o,
  output logic [7:0]            read_data_o,
  output logic                  bus_driven_o
);
  import dhglc_pkg::*;

  logic [HALVES-1:0]             sel;
  logic [HALVES-1:0][PAGE_W-1:0] page_q;
  logic [HALVES-1:0][COL_W-1:0]  col_q;
  logic [HALVES-1:0][COL_W-1:0]  col_next;
  logic [HALVES-1:0][LINE_W-1:0] line_q;
  logic [HALVES-1:0]             en_q;
  logic [HALVES-1:0][7:0]        latch_q;
  logic [HALVES-1:0]             pend_q;
  logic [HALVES-1:0][7:0]        rdata;
  logic [HALVES-1:0][7:0]        half_res;
  logic [HALVES-1:0][RAM_AW-1:0] addr;
  logic                          is_read;
  logic                          instr_acc;
  logic [7:0]                    read_data_q;
  logic                          bus_driven_q;

  // Half decode
  assign sel[0]  = (cs_i == CS_BOTH) || (cs_i == CS_LEFT);
  assign sel[1]  = (cs_i == CS_BOTH) || (cs_i == CS_RIGHT);
  assign is_read = (kind_i == KIND_STATUS) || (kind_i == KIND_DATA_RD);
  assign status_o.dread_sel = (kind_i == KIND_DATA_RD) && (|sel);
  assign instr_acc = cmd_i.acc_en && (kind_i == KIND_INSTR);

  // Address, column step and read byte of each half
  always_comb begin
    for (int h = 0; h < HALVES; h++) begin
      addr[h] = {page_q[h][PAGE_AW-1:0], col_q[h][COL_AW-1:0]};
      if (col_q[h] == COL_W'(COLUMNS - 1)) begin
        col_next[h] = '0;
      end else begin
        col_next[h] = col_q[h] + 1'b1;
      end
      if (kind_i == KIND_STATUS) begin
        half_res[h] = en_q[h] ? 8'h00 : STATUS_OFF;
      end else begin
        half_res[h] = latch_q[h];
      end
    end
  end

  // Display RAM per half: clear sweep or data write, synchronous read
  for (genvar g = 0; g < HALVES; g++) begin : g_ram
    logic [7:0]        mem [RAM_DEPTH];
    logic [7:0]        rdata_q;
    logic              we;
    logic [RAM_AW-1:0] wa;
    logic [7:0]        wd;

    assign we = cmd_i.clr_en || (cmd_i.acc_en && sel[g] && (kind_i == KIND_DATA_WR));
    assign wa = cmd_i.clr_en ? cmd_i.clr_addr : addr[g];
    assign wd = cmd_i.clr_en ? 8'h00 : bus_data_i;

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[wa] <= wd;
      end
      rdata_q <= mem[addr[g]];
    end

    assign rdata[g] = rdata_q;
  end

  // Per-half control registers and output latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      col_q   <= '0;
      line_q  <= '0;
      en_q    <= '0;
      latch_q <= '0;
      pend_q  <= '0;
    end else begin
      for (int h = 0; h < HALVES; h++) begin
        pend_q[h] <= cmd_i.acc_en && sel[h] && (kind_i == KIND_DATA_RD);
        if (cmd_i.acc_en && sel[h]) begin
          case (kind_i)
            KIND_INSTR: begin
              if (bus_data_i == INSTR_OFF || bus_data_i == INSTR_ON) begin
                en_q[h] <= bus_data_i[0];
              end else if ((bus_data_i & INSTR_COL_MASK) == INSTR_COL) begin
                col_q[h] <= bus_data_i[COL_W-1:0];
              end else if ((bus_data_i & INSTR_PAGE_MASK) == INSTR_PAGE) begin
                page_q[h] <= bus_data_i[PAGE_W-1:0];
              end else if ((bus_data_i & INSTR_LINE_MASK) == INSTR_LINE) begin
                line_q[h] <= bus_data_i[LINE_W-1:0];
              end
            end
            KIND_DATA_WR, KIND_DATA_RD: begin
              col_q[h] <= col_next[h];
            end
            default: ;
          endcase
        end
        // reload the latch with the byte fetched on the previous cycle
        if (cmd_i.latch_ld && pend_q[h]) begin
          latch_q[h] <= rdata[h];
        end
      end
    end
  end

  // Result register; left half drives the bus when both are selected
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      if (is_read && (|sel)) begin
        read_data_q  <= sel[0] ? half_res[0] : half_res[1];
        bus_driven_q <= 1'b1;
      end else begin
        read_data_q  <= 8'h00;
        bus_driven_q <= 1'b0;
      end
    end
  end

  assign read_data_o  = read_data_q;
  assign bus_driven_o = bus_driven_q;

  `DHGLC_ASSERT(a_line_hold, !instr_acc |=> $stable(line_q), "start line changed without instruction")
  `DHGLC_ASSERT(a_latch_hold, !cmd_i.latch_ld |=> $stable(latch_q), "output latch changed outside reload")
  `DHGLC_ASSERT(a_pend_load, (|pend_q) |-> cmd_i.latch_ld, "pending latch reload not issued")

endmodule

// ===== hdl/dual_half_graphic_lcd_controller.sv =====
// Top level of the dual-half graphic LCD controller.
// Usage:
//   in_i carries one bus access per request: kind (instruction write, data
//   write, status read, data read), chip_select (both, left, right, none)
//   and bus_data. out_o returns one result per access: read_data (status
//   byte or latched display byte, zero for writes) and bus_driven.
//   Latency: the result is valid on the cycle after the request is taken.
//   Throughput: one request per cycle for instructions, data writes,
//   status reads and unselected accesses; a selected data read holds off
//   the next request while the output latch reloads from the registered
//   RAM read port on the cycle after the request.
//   Reset: all half registers and latches clear; the display RAM (512
//   bytes per half, both halves in parallel) is zeroed by a sweep over
//   every address, during which in_i.ready stays low.
//   Stall: one result register sits between the channels; while it holds
//   an untaken result, a new request is taken only in the cycle in which
//   out_o.ready takes the held one.
module dual_half_graphic_lcd_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  dhglc_in_if.sink          in_i,
  dhglc_out_if.source       out_o
);
  import dhglc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dhglc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dhglc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_e'(in_i.kind)),
    .cs_i         (cs_e'(in_i.chip_select)),
    .bus_data_i   (in_i.bus_data),
    .status_o     (status),
    .read_data_o  (out_o.read_data),
    .bus_driven_o (out_o.bus_driven)
  );

endmodule
